// ===== rtl/bps_pkg.sv =====
package bps_pkg;

  localparam int MAX_LINES  = 4096;
  localparam int LINE_IDX_W = $clog2(MAX_LINES);
  localparam int COORD_W    = 13;
  localparam int DIR_W      = 2;
  localparam int LC_W       = 13;
  localparam int LIM_W      = 12;
  localparam int ROI_W      = 12;
  localparam int DONE_W     = 12;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_SCAN_DIR   = 2'd0;
  localparam logic [1:0] REG_LINE_COUNT = 2'd1;
  localparam logic [1:0] REG_SEG_LIMIT  = 2'd2;
  localparam logic [1:0] REG_ROI_OFFSET = 2'd3;

  localparam logic [LC_W-1:0] LINE_COUNT_RST = LC_W'(4096);

  typedef struct packed {
    logic pixel_on;
    logic line_end;
    logic image_end;
  } bps_in_t;

  typedef struct packed {
    logic               has_segment;
    logic [COORD_W-1:0] seg_low;
    logic [COORD_W-1:0] seg_high;
    logic               last;
  } bps_out_t;

  typedef struct packed {
    logic [DIR_W-1:0] scan_direction;
    logic [LC_W-1:0]  line_count;
    logic [LIM_W-1:0] segment_limit;
    logic [ROI_W-1:0] roi_offset;
  } bps_cfg_t;

endpackage

// ===== rtl/bps_regs.sv =====
module bps_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bps_pkg::ADDR_W-1:0] paddr,
  input  logic [bps_pkg::DATA_W-1:0] pwdata,
  output logic [bps_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bps_pkg::bps_cfg_t          cfg
);
  import bps_pkg::*;

  bps_cfg_t   cfg_r;
  bps_cfg_t   cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SCAN_DIR:   cfg_nxt.scan_direction = pwdata[DIR_W-1:0];
        REG_LINE_COUNT: cfg_nxt.line_count     = pwdata[LC_W-1:0];
        REG_SEG_LIMIT:  cfg_nxt.segment_limit  = pwdata[LIM_W-1:0];
        REG_ROI_OFFSET: cfg_nxt.roi_offset     = pwdata[ROI_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_direction <= '0;
      cfg_r.line_count     <= LINE_COUNT_RST;
      cfg_r.segment_limit  <= '0;
      cfg_r.roi_offset     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCAN_DIR:   prdata = DATA_W'(cfg_r.scan_direction);
      REG_LINE_COUNT: prdata = DATA_W'(cfg_r.line_count);
      REG_SEG_LIMIT:  prdata = DATA_W'(cfg_r.segment_limit);
      REG_ROI_OFFSET: prdata = DATA_W'(cfg_r.roi_offset);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bps_core.sv =====
module bps_core (
  input  logic               clk,
  input  logic               rst_n,
  input  bps_pkg::bps_cfg_t  cfg,
  input  logic               step,
  input  bps_pkg::bps_in_t   item,
  output logic               res_valid,
  output bps_pkg::bps_out_t  res
);
  import bps_pkg::*;

  logic                  lhp_r, lhp_nxt;
  logic                  in_seg_r, in_seg_nxt;
  logic [LINE_IDX_W-1:0] idx_r, idx_nxt;
  logic [COORD_W-1:0]    open_r, open_nxt;
  logic [DONE_W-1:0]     done_r, done_nxt;
  logic                  lim_r, lim_nxt;

  logic               back;
  logic               lhp;
  logic               le;
  logic [COORD_W-1:0] idx_c;
  logic [COORD_W-1:0] c_line;
  logic [COORD_W-1:0] c_edge;
  logic [COORD_W-1:0] closing;
  logic [COORD_W-1:0] open_after;
  logic [DONE_W-1:0]  done_inc;
  logic               open_now;
  logic               close_now;
  logic               in_seg_after;
  logic               lim_after;
  logic               edge_close;
  logic               has_seg;

  assign back  = cfg.scan_direction[0];
  assign lhp   = lhp_r | (item.pixel_on & ~lim_r);
  assign le    = item.line_end | item.image_end;
  assign idx_c = COORD_W'(idx_r);

  // Backward scans report a line's position plus one.
  assign c_line = (back ? (COORD_W'(cfg.line_count) - idx_c) : idx_c)
                  + COORD_W'(cfg.roi_offset);
  assign c_edge = (back ? '0 : COORD_W'(cfg.line_count)) + COORD_W'(cfg.roi_offset);

  assign open_now  = le & ~lim_r & lhp & ~in_seg_r;
  assign close_now = le & ~lim_r & ~lhp & in_seg_r;
  assign done_inc  = (done_r == {DONE_W{1'b1}}) ? done_r : done_r + 1'b1;

  assign in_seg_after = open_now | (in_seg_r & ~close_now);
  assign lim_after    = lim_r | (close_now & (cfg.segment_limit != '0)
                                 & (done_inc == DONE_W'(cfg.segment_limit)));
  assign open_after   = open_now ? c_line : open_r;

  // A segment still open when the image ends closes at the image edge.
  assign edge_close = item.image_end & ~close_now & in_seg_after & ~lim_after;
  assign has_seg    = close_now | edge_close;
  assign closing    = close_now ? c_line : c_edge;

  assign res_valid       = close_now | item.image_end;
  assign res.has_segment = has_seg;
  assign res.seg_low     = has_seg ? (back ? closing : open_after) : '0;
  assign res.seg_high    = has_seg ? (back ? open_after : closing) : '0;
  assign res.last        = item.image_end;

  always_comb begin
    lhp_nxt    = lhp;
    in_seg_nxt = in_seg_after;
    idx_nxt    = idx_r;
    open_nxt   = open_after;
    done_nxt   = close_now ? done_inc : done_r;
    lim_nxt    = lim_after;
    if (le) begin
      lhp_nxt = 1'b0;
      if (idx_r != LINE_IDX_W'(MAX_LINES - 1)) begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (item.image_end) begin
      lhp_nxt    = 1'b0;
      in_seg_nxt = 1'b0;
      idx_nxt    = '0;
      open_nxt   = '0;
      done_nxt   = '0;
      lim_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhp_r    <= 1'b0;
      in_seg_r <= 1'b0;
      idx_r    <= '0;
      open_r   <= '0;
      done_r   <= '0;
      lim_r    <= 1'b0;
    end else if (step) begin
      lhp_r    <= lhp_nxt;
      in_seg_r <= in_seg_nxt;
      idx_r    <= idx_nxt;
      open_r   <= open_nxt;
      done_r   <= done_nxt;
      lim_r    <= lim_nxt;
    end
  end

endmodule

// ===== rtl/binary_projection_segmenter.sv =====
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  bps_in_t: pixel_on, line_end, image_end
// out_      output     out_valid/out_stall bps_out_t: has_segment, seg_low, seg_high, last
// cfg_      APB        psel/penable       four registers at byte address 4*i
//
// One pixel beat is taken per cycle unless the output stalls; a beat that yields a
// result goes through one input register and the segment logic to the result register.
// Reset clears the image state, both valid flags and the registers to their defaults.
// A stalled result holds the input register, which then stalls the input side.
module binary_projection_segmenter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bps_pkg::bps_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bps_pkg::bps_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bps_pkg::ADDR_W-1:0] paddr,
  input  logic [bps_pkg::DATA_W-1:0] pwdata,
  output logic [bps_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bps_pkg::*;

  bps_cfg_t cfg;
  bps_in_t  s1_item_r;
  logic     s1_valid_r, s1_valid_nxt;
  bps_out_t out_data_r;
  logic     out_valid_r, out_valid_nxt;
  logic     adv;
  logic     in_acc;
  logic     res_valid;
  bps_out_t res;

  bps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (adv),
    .item      (s1_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // The held beat moves on when the result register is empty or being drained.
  assign adv      = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~adv;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (adv & res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (adv & res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
